@@ rtl/lant_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lant_pkg;

  // Grid storage limits
  localparam int MAX_W = 256;
  localparam int MAX_H = 256;
  localparam int COL_W = $clog2(MAX_W);
  localparam int ROW_W = $clog2(MAX_H);

  // Field widths
  localparam int SIZE_W  = 9;
  localparam int POS_W   = 10;
  localparam int CNT_W   = 32;
  localparam int PEEK_W  = 8;
  localparam int CFG_IDX_W = 1;

  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 64;

  localparam logic [SIZE_W-1:0] GRID_RST = 9'd64;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_TOGGLE = 2'd1,
    CMD_STEP   = 2'd2,
    CMD_RESET  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLR_BOOT,
    ST_IDLE,
    ST_EXEC,
    ST_CLR_CMD,
    ST_REPORT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic             rd_en;     // latch item, read ant row and peek row
    logic             exec_en;   // run the command, write back, form result
    logic             restart;   // home the ant, zero count, pause
    logic             clr_we;    // clear one row
    logic [ROW_W-1:0] clr_row;
    logic             out_load;  // load the result register
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic logic pos_in_grid(logic signed [POS_W-1:0] x,
                                       logic signed [POS_W-1:0] y,
                                       logic [SIZE_W-1:0]       w,
                                       logic [SIZE_W-1:0]       h);
    logic signed [POS_W-1:0] ws;
    logic signed [POS_W-1:0] hs;
    ws = signed'({1'b0, w});
    hs = signed'({1'b0, h});
    return (x >= 0) && (x < ws) && (y >= 0) && (y < hs);
  endfunction

endpackage

`default_nettype wire

@@ rtl/lant_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lant_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  lant_pkg::cmd_t  in_cmd,
  input  lant_pkg::sts_t  sts,
  output lant_pkg::ctl_t  ctl
);
  import lant_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [ROW_W-1:0] clr_row;
  logic [ROW_W-1:0] clr_row_next;
  logic             accept;
  logic             last_row;

  assign accept   = in_valid && in_ready;
  assign last_row = (clr_row == ROW_W'(MAX_H - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLR_BOOT;
      clr_row <= '0;
    end else begin
      state   <= state_next;
      clr_row <= clr_row_next;
    end
  end

  always_comb begin
    state_next   = state;
    clr_row_next = clr_row;
    in_ready     = 1'b0;
    ctl          = '0;
    ctl.clr_row  = clr_row;
    case (state)
      ST_CLR_BOOT: begin
        ctl.clr_we   = 1'b1;
        clr_row_next = clr_row + 1'b1;
        if (last_row) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        ctl.rd_en  = in_valid;
        if (accept) begin
          if (in_cmd == CMD_RESET) begin
            ctl.restart  = 1'b1;
            clr_row_next = '0;
            state_next   = ST_CLR_CMD;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          ctl.exec_en  = 1'b1;
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_CLR_CMD: begin
        ctl.clr_we   = 1'b1;
        clr_row_next = clr_row + 1'b1;
        if (last_row) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLR_BOOT;
      end
    endcase
  end

  a_exec_returns: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && sts.out_free) |=> state == ST_IDLE)
    else $error("exec did not return to idle");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.restart |=> (state == ST_CLR_CMD && clr_row == '0))
    else $error("reset command did not start a clearing pass at row zero");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLR_BOOT || state == ST_CLR_CMD) |-> !in_ready)
    else $error("input taken during a clearing pass");

endmodule

`default_nettype wire

@@ rtl/lant_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lant_dp (
  input  wire                                clk,
  input  wire                                rst,
  input  lant_pkg::cmd_t                     in_cmd,
  input  wire [lant_pkg::PEEK_W-1:0]         in_peek_x,
  input  wire [lant_pkg::PEEK_W-1:0]         in_peek_y,
  input  wire                                cfg_we,
  input  wire [lant_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [lant_pkg::SIZE_W-1:0]         cfg_data,
  input  lant_pkg::ctl_t                     ctl,
  output lant_pkg::sts_t                     sts,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [lant_pkg::M_DATA_W-1:0]      m_tdata
);
  import lant_pkg::*;

  logic [MAX_W-1:0] mem [MAX_H];

  logic [SIZE_W-1:0] grid_width;
  logic [SIZE_W-1:0] grid_height;
  logic [SIZE_W-1:0] used_w;
  logic [SIZE_W-1:0] used_h;

  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [1:0]              dir_reg;
  logic [CNT_W-1:0]        iter_count;
  logic                    run_flag;

  cmd_t              cmd_q;
  logic [PEEK_W-1:0] peek_x_q;
  logic [PEEK_W-1:0] peek_y_q;
  logic [MAX_W-1:0]  ant_row;
  logic [MAX_W-1:0]  peek_row;

  logic                    allowed;
  logic                    step;
  logic                    cur_bit;
  logic [1:0]              dir_next;
  logic signed [POS_W-1:0] pos_x_next;
  logic signed [POS_W-1:0] pos_y_next;
  logic [CNT_W-1:0]        iter_count_next;
  logic                    run_flag_next;
  logic [MAX_W-1:0]        ant_row_next;
  logic                    peek_bit;
  logic                    peek_hit;
  logic                    oob_next;

  assign used_w = (grid_width  > SIZE_W'(MAX_W)) ? SIZE_W'(MAX_W) : grid_width;
  assign used_h = (grid_height > SIZE_W'(MAX_H)) ? SIZE_W'(MAX_H) : grid_height;

  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_RST;
      grid_height <= GRID_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Latch the item and read both rows
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      cmd_q    <= in_cmd;
      peek_x_q <= in_peek_x;
      peek_y_q <= in_peek_y;
      ant_row  <= mem[pos_y[ROW_W-1:0]];
      peek_row <= mem[in_peek_y[ROW_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr_we) begin
      mem[ctl.clr_row] <= '0;
    end else if (step) begin
      mem[pos_y[ROW_W-1:0]] <= ant_row_next;
    end
  end

  always_comb begin
    allowed = pos_in_grid(pos_x, pos_y, used_w, used_h);
    step    = 1'b0;
    run_flag_next = run_flag;
    if (ctl.exec_en && allowed) begin
      case (cmd_q)
        CMD_TICK:   step = run_flag;
        CMD_TOGGLE: begin
          run_flag_next = !run_flag;
          step          = !run_flag;
        end
        CMD_STEP:   step = 1'b1;
        default:    step = 1'b0;
      endcase
    end

    cur_bit  = ant_row[pos_x[COL_W-1:0]];
    dir_next = cur_bit ? (dir_reg - 2'd1) : (dir_reg + 2'd1);

    ant_row_next = ant_row;
    ant_row_next[pos_x[COL_W-1:0]] = !cur_bit;

    pos_x_next      = pos_x;
    pos_y_next      = pos_y;
    iter_count_next = iter_count;
    if (step) begin
      iter_count_next = iter_count + 1'b1;
      case (dir_next)
        2'd0:    pos_y_next = pos_y - POS_W'(1);
        2'd1:    pos_x_next = pos_x + POS_W'(1);
        2'd2:    pos_y_next = pos_y + POS_W'(1);
        default: pos_x_next = pos_x - POS_W'(1);
      endcase
    end

    // Peek sees the cell after this item's flip
    peek_hit = step && (peek_x_q == pos_x[COL_W-1:0]) && (peek_y_q == pos_y[ROW_W-1:0]);
    peek_bit = 1'b0;
    if (ctl.exec_en && ({1'b0, peek_x_q} < used_w) && ({1'b0, peek_y_q} < used_h)) begin
      peek_bit = peek_row[peek_x_q] ^ peek_hit;
    end

    oob_next = !pos_in_grid(pos_x_next, pos_y_next, used_w, used_h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x      <= signed'(POS_W'(GRID_RST >> 1));
      pos_y      <= signed'(POS_W'(GRID_RST >> 1));
      dir_reg    <= 2'd0;
      iter_count <= '0;
      run_flag   <= 1'b0;
    end else if (ctl.restart) begin
      pos_x      <= signed'(POS_W'(used_w >> 1));
      pos_y      <= signed'(POS_W'(used_h >> 1));
      dir_reg    <= 2'd0;
      iter_count <= '0;
      run_flag   <= 1'b0;
    end else if (ctl.exec_en) begin
      pos_x      <= pos_x_next;
      pos_y      <= pos_y_next;
      iter_count <= iter_count_next;
      run_flag   <= run_flag_next;
      if (step) begin
        dir_reg <= dir_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      m_tdata <= {7'd0, peek_bit, oob_next, run_flag_next, iter_count_next,
                  (step ? dir_next : dir_reg), pos_y_next, pos_x_next};
    end
  end

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    ctl.exec_en |-> !ctl.clr_we)
    else $error("row clear and step write in the same cycle");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> !(m_tvalid && !m_tready))
    else $error("result overwritten before it was taken");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !(ctl.exec_en || ctl.restart) |=> $stable(iter_count))
    else $error("step count moved without a command");

endmodule

`default_nettype wire

@@ rtl/langtons_ant_stepper_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                 Payload
// s_*       in   s_tvalid / s_tready       s_tdata: command word, 24 bits
// m_*       out  m_tvalid / m_tready       m_tdata: result word, 64 bits
// cfg_*     in   cfg_valid / cfg_ready     cfg_index, cfg_data (grid size)
//
// An item is taken in the accept cycle, which reads the ant row and the peek
// row from the cell memory; the execute state then writes the row back and
// loads the result register. A reset command adds one clearing pass over all
// 256 memory rows (one memory row per cycle) before its result word.
// After rst the same clearing pass runs with s_tready low;
// configuration writes are taken at any time (cfg_ready stays high).
// A result waiting on m_tready does not block the next accept; the block
// holds in its write-back cycle only until the result register frees.
module langtons_ant_stepper_top (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // s_tdata, low bit up: cmd[1:0], peek_x[9:2], peek_y[17:10], zero pad
  input  wire [lant_pkg::S_DATA_W-1:0]        s_tdata,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // m_tdata, low bit up: ant_x[9:0], ant_y[19:10], heading[21:20],
  // step_count[53:22], is_running[54], off_grid[55], peek_cell[56],
  // zero pad
  output logic [lant_pkg::M_DATA_W-1:0]       m_tdata,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [lant_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [lant_pkg::SIZE_W-1:0]          cfg_data
);
  import lant_pkg::*;

  ctl_t              ctl;
  sts_t              sts;
  cmd_t              in_cmd;
  logic [PEEK_W-1:0] in_peek_x;
  logic [PEEK_W-1:0] in_peek_y;

  // Unpack the command word
  assign in_cmd    = cmd_t'(s_tdata[1:0]);
  assign in_peek_x = s_tdata[9:2];
  assign in_peek_y = s_tdata[17:10];

  // Size registers are plain flops: always ready
  assign cfg_ready = 1'b1;

  lant_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (in_cmd),
    .sts      (sts),
    .ctl      (ctl)
  );

  lant_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_cmd    (in_cmd),
    .in_peek_x (in_peek_x),
    .in_peek_y (in_peek_y),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

// Self-checking bench for langtons_ant_stepper_top.
// A local ant model tracks grid, position, heading, count and run flag.
// Every command word accepted on s_* produces one predicted result word.
// The result word seen on m_* is compared field by field with the oldest
// prediction.
module tb_top;
  import lant_pkg::*;

  // One predicted result word, unpacked into its fields
  typedef struct {
    logic [POS_W-1:0] ant_x;
    logic [POS_W-1:0] ant_y;
    logic [1:0]       heading;
    logic [CNT_W-1:0] step_count;
    logic             is_running;
    logic             off_grid;
    logic             peek_cell;
  } ant_view_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  langtons_ant_stepper_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Local copy of the ant world
  bit [MAX_W*MAX_H-1:0] trail_cells;
  int                   ant_col;
  int                   ant_row;
  logic [1:0]           ant_dir;
  logic [CNT_W-1:0]     ant_steps;
  bit                   ant_run;
  logic [SIZE_W-1:0]    cols_reg;
  logic [SIZE_W-1:0]    rows_reg;

  ant_view_t pending_views[$];

  int mismatch_count = 0;
  int words_checked  = 0;
  int words_sent     = 0;
  int total_moves    = 0;
  int offgrid_words  = 0;
  int grid_settings  = 0;
  int burst_left     = 0;

  // Clock: 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well past the slowest legal run (every word a reset command
  // behind a stalled receiver)
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  // Size registers above the store size clamp to the store size
  function automatic int used_cols();
    return (cols_reg > MAX_W) ? MAX_W : int'(cols_reg);
  endfunction

  function automatic int used_rows();
    return (rows_reg > MAX_H) ? MAX_H : int'(rows_reg);
  endfunction

  function automatic bit on_grid(int x, int y);
    return (x >= 0) && (x < used_cols()) && (y >= 0) && (y < used_rows());
  endfunction

  // Clear the trail, park the ant at the centre facing north, pause
  function automatic void home_ant();
    trail_cells = '0;
    ant_col     = used_cols() / 2;
    ant_row     = used_rows() / 2;
    ant_dir     = 2'd0;
    ant_steps   = '0;
    ant_run     = 1'b0;
  endfunction

  // One iteration: turn right on white, left on black, flip, move
  function automatic void move_ant();
    int idx;
    bit shade;
    idx   = ant_row * MAX_W + ant_col;
    shade = trail_cells[idx];
    ant_steps = ant_steps + 1'b1;
    ant_dir   = shade ? ant_dir - 2'd1 : ant_dir + 2'd1;
    trail_cells[idx] = ~shade;
    total_moves++;
    case (ant_dir)
      2'd0: ant_row--;
      2'd1: ant_col++;
      2'd2: ant_row++;
      default: ant_col--;
    endcase
  endfunction

  // Advance the model by one command word and return the expected result
  function automatic ant_view_t predict_view(cmd_t op, logic [7:0] px, logic [7:0] py);
    ant_view_t v;
    bit        can_move;
    can_move = on_grid(ant_col, ant_row);
    case (op)
      CMD_TOGGLE: if (can_move) ant_run = !ant_run;
      CMD_STEP:   if (!ant_run && can_move) move_ant();
      CMD_RESET:  home_ant();
      default: ;
    endcase
    // A running ant steps on every word, so a starting toggle steps too
    if (ant_run && can_move) move_ant();
    v.ant_x      = ant_col[POS_W-1:0];
    v.ant_y      = ant_row[POS_W-1:0];
    v.heading    = ant_dir;
    v.step_count = ant_steps;
    v.is_running = ant_run;
    v.off_grid   = !on_grid(ant_col, ant_row);
    v.peek_cell  = on_grid(px, py) ? trail_cells[py * MAX_W + px] : 1'b0;
    if (v.off_grid) offgrid_words++;
    return v;
  endfunction

  task automatic flag_mismatch(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("MISMATCH word %0d %s: got 0x%0h want 0x%0h", words_checked, what, got, want);
  endtask

  // Send one command word. Bursts of random length with random gaps in
  // between; hold tvalid high across back-to-back words.
  task automatic send_word(cmd_t op, logic [7:0] px, logic [7:0] py);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 16);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_DATA_W-18){1'b0}}, py, px, op};
    do @(posedge clk); while (!s_tready);
    // Word taken at this edge: predict it now, in issue order
    pending_views.push_back(predict_view(op, px, py));
    words_sent++;
    burst_left--;
  endtask

  // Pick a peek cell: mostly around the ant, some inside the grid, some anywhere
  task automatic send_near(cmd_t op);
    logic [7:0] px;
    logic [7:0] py;
    case ($urandom_range(0, 3))
      0, 1: begin
        px = 8'(ant_col + int'($urandom_range(0, 4)) - 2);
        py = 8'(ant_row + int'($urandom_range(0, 4)) - 2);
      end
      2: begin
        px = 8'($urandom_range(0, (used_cols() > 0) ? used_cols() - 1 : 0));
        py = 8'($urandom_range(0, (used_rows() > 0) ? used_rows() - 1 : 0));
      end
      default: begin
        px = 8'($urandom_range(0, 255));
        py = 8'($urandom_range(0, 255));
      end
    endcase
    send_word(op, px, py);
  endtask

  // Drop tvalid, wait for every predicted word, then let the block settle
  task automatic wait_drained();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both size registers while the block is idle
  task automatic set_grid(logic [SIZE_W-1:0] cols, logic [SIZE_W-1:0] rows);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data  <= cols;
    do @(posedge clk); while (!cfg_ready);
    cols_reg  = cols;
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data  <= rows;
    do @(posedge clk); while (!cfg_ready);
    rows_reg  = rows;
    cfg_valid <= 1'b0;
    grid_settings++;
    @(posedge clk);
  endtask

  // Every command on the default 64 x 64 grid, peeks at the field extremes
  task automatic test_basic_commands();
    send_word(CMD_TICK,   8'd0,   8'd0);    // paused: nothing moves
    send_word(CMD_STEP,   8'd32,  8'd32);   // one step, peek the flipped cell
    send_word(CMD_STEP,   8'd255, 8'd255);  // peek far outside the grid
    send_word(CMD_TOGGLE, 8'd32,  8'd32);   // start running, steps as well
    send_word(CMD_TICK,   8'd33,  8'd32);
    send_word(CMD_TICK,   8'd33,  8'd33);
    send_word(CMD_TICK,   8'd32,  8'd33);
    send_word(CMD_STEP,   8'd32,  8'd32);   // while running acts as a tick
    send_word(CMD_TOGGLE, 8'd31,  8'd32);   // pause
    send_word(CMD_TICK,   8'd63,  8'd63);
    send_word(CMD_STEP,   8'd64,  8'd0);
    send_word(CMD_TICK,   8'd0,   8'd64);
    send_word(CMD_RESET,  8'd32,  8'd32);   // trail cleared
    send_word(CMD_TICK,   8'd170, 8'd85);
  endtask

  // One-cell and empty grids: the ant leaves at once or never starts
  task automatic test_stuck_ant();
    set_grid(9'd1, 9'd1);
    send_word(CMD_RESET,  8'd0, 8'd0);
    send_word(CMD_STEP,   8'd0, 8'd0);      // steps off the grid
    send_word(CMD_TOGGLE, 8'd0, 8'd0);      // off grid: toggle ignored
    send_word(CMD_STEP,   8'd0, 8'd0);
    send_word(CMD_TICK,   8'd1, 8'd0);
    send_word(CMD_RESET,  8'd0, 8'd0);
    send_word(CMD_TOGGLE, 8'd0, 8'd0);      // run and leave on the same word
    send_word(CMD_TICK,   8'd0, 8'd0);
    send_word(CMD_TOGGLE, 8'd0, 8'd0);      // still running, cannot stop
    send_word(CMD_RESET,  8'd0, 8'd0);
    set_grid(9'd0, 9'd0);
    send_word(CMD_TICK,   8'd0, 8'd0);      // ant keeps the old centre
    send_word(CMD_RESET,  8'd0, 8'd0);
    send_word(CMD_TOGGLE, 8'd0, 8'd0);
    send_word(CMD_STEP,   8'd0, 8'd0);
  endtask

  // Size registers above the store size clamp to 256
  task automatic test_oversized_grid();
    set_grid(9'd511, 9'd300);
    send_word(CMD_RESET,  8'd128, 8'd128);
    send_word(CMD_TOGGLE, 8'd128, 8'd128);
    repeat (6) send_near(CMD_TICK);
    send_word(CMD_TICK,   8'd255, 8'd255);
    send_word(CMD_TOGGLE, 8'd0,   8'd0);
    set_grid(9'd256, 9'd256);
    send_word(CMD_STEP,   8'd255, 8'd0);
  endtask

  // Shrink and regrow without a reset: the trail outside the in-use area
  // hides from the peek but survives
  task automatic test_size_change();
    set_grid(9'd8, 9'd8);
    send_word(CMD_RESET,  8'd4, 8'd4);
    send_word(CMD_TOGGLE, 8'd4, 8'd4);
    repeat (12) send_near(CMD_TICK);
    set_grid(9'd2, 9'd3);
    repeat (8) send_word(CMD_TICK, 8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)));
    set_grid(9'd8, 9'd8);
    repeat (10) send_word(CMD_STEP, 8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)));
    send_word(CMD_RESET, 8'd4, 8'd4);
  endtask

  // Random walks: mostly well-formed run/step traffic for the current state,
  // some noise words with any command and any peek
  task automatic send_walk_word();
    cmd_t op;
    int   roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      op = cmd_t'($urandom_range(0, 3));
      send_word(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end else begin
      if (!on_grid(ant_col, ant_row))
        op = (roll < 70) ? CMD_RESET : CMD_TICK;
      else if (ant_run)
        op = (roll < 85) ? CMD_TICK : ((roll < 95) ? CMD_STEP : CMD_TOGGLE);
      else
        op = (roll < 60) ? CMD_STEP : ((roll < 85) ? CMD_TOGGLE : CMD_TICK);
      send_near(op);
    end
  endtask

  task automatic test_random_walks();
    int cols;
    int rows;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin cols = 256; rows = 256; end
        1: begin cols = 0;   rows = $urandom_range(1, 8); end
        2: begin cols = 511; rows = 1; end
        3: begin cols = $urandom_range(0, 511); rows = $urandom_range(0, 511); end
        default: begin cols = $urandom_range(1, 16); rows = $urandom_range(1, 16); end
      endcase
      set_grid(9'(cols), 9'(rows));
      send_near(CMD_RESET);
      for (int n = 0; n < 157; n++) begin
        // Now and then hold off until every result word is back
        if ($urandom_range(0, 99) == 0) wait_drained();
        send_walk_word();
      end
    end
  endtask

  // Receiver: pick a new random stall pattern whenever the current one runs out
  initial begin
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 1) != 0);
        default: m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Result checker: compare each taken result word with the oldest prediction
  always @(posedge clk) begin
    ant_view_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_views.size() == 0) begin
        flag_mismatch("unexpected result word", m_tdata[CNT_W-1:0], '0);
      end else begin
        want = pending_views.pop_front();
        if (m_tdata[9:0] !== want.ant_x)
          flag_mismatch("ant_x", m_tdata[9:0], want.ant_x);
        if (m_tdata[19:10] !== want.ant_y)
          flag_mismatch("ant_y", m_tdata[19:10], want.ant_y);
        if (m_tdata[21:20] !== want.heading)
          flag_mismatch("heading", m_tdata[21:20], want.heading);
        if (m_tdata[53:22] !== want.step_count)
          flag_mismatch("step_count", m_tdata[53:22], want.step_count);
        if (m_tdata[54] !== want.is_running)
          flag_mismatch("is_running", m_tdata[54], want.is_running);
        if (m_tdata[55] !== want.off_grid)
          flag_mismatch("off_grid", m_tdata[55], want.off_grid);
        if (m_tdata[56] !== want.peek_cell)
          flag_mismatch("peek_cell", m_tdata[56], want.peek_cell);
      end
      words_checked++;
    end
  end

  initial begin
    // Drive every input from time zero, hold reset, then release it
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data  <= '0;
    cols_reg  = GRID_RST;
    rows_reg  = GRID_RST;
    home_ant();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // The clearing pass after reset holds s_tready low; the send waits it out
    test_basic_commands();
    test_stuck_ant();
    test_oversized_grid();
    test_size_change();
    test_random_walks();

    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_views.size() != 0)
      flag_mismatch("result words missing", pending_views.size(), 0);

    $display("Covered %0d command words over %0d grid settings, %0d result words checked.",
             words_sent, grid_settings, words_checked);
    $display("Ant moved %0d times; %0d results had the ant off the grid.",
             total_moves, offgrid_words);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/lant_pkg.sv
rtl/lant_ctrl.sv
rtl/lant_dp.sv
rtl/langtons_ant_stepper_top.sv
test/tb_top.sv
